>>> sv/bend_sensor_to_dac_mapper_defines.svh
// Assertion macros shared by the bend sensor mapper checking code.
`ifndef BEND_SENSOR_TO_DAC_MAPPER_DEFINES_SVH
`define BEND_SENSOR_TO_DAC_MAPPER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define BSDM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("bend mapper check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define BSDM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("bend mapper check failed");

`endif

>>> sv/bsdm_pkg.sv
// Types, constants and codes shared by the bend sensor mapper modules.
`default_nettype none
package bsdm_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam logic [15:0] SAMPLE_MASK =
		(SAMPLE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << SAMPLE_BITS) - 32'd1);

	localparam logic [16:0] CAL_MARGIN = 17'd1000;
	localparam int ALU_W = 34;
	localparam int DIV_STEPS = 16;
	localparam int MUL_STEPS = 17;
	localparam int CNT_W = 5;
	localparam logic [31:0] ACC_RESET = 32'h8000_0000;
	localparam logic [16:0] Q16_ONE = 17'h10000;
	localparam logic [31:0] ROUND_HALF = 32'h0000_8000;

	localparam logic [2:0] REG_ZERO_POINT = 3'd0;
	localparam logic [2:0] REG_IDLE_THRESHOLD = 3'd1;
	localparam logic [2:0] REG_OUTPUT_RANGE = 3'd2;
	localparam logic [2:0] REG_DAC_CENTER = 3'd3;
	localparam logic [2:0] REG_FILTER_ALPHA = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_UP = 2'd1,
		ST_DOWN = 2'd2
	} bend_st_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_CLASS,
		SQ_DIV,
		SQ_MUL1,
		SQ_TGT,
		SQ_DIFF,
		SQ_NEG,
		SQ_MUL2,
		SQ_ACC,
		SQ_CODE
	} seq_st_t;

	typedef struct packed {
		logic inv;
		logic cin;
	} alu_op_t;

endpackage
`default_nettype wire

>>> sv/bsdm_alu.sv
// Shared adder and subtractor used by the divide, multiply, target, filter and code steps of the mapper.
`default_nettype none
module bsdm_alu
	import bsdm_pkg::*;
(
	input  wire logic [ALU_W-1:0] a,
	input  wire logic [ALU_W-1:0] b,
	input  wire alu_op_t          op,
	output logic [ALU_W-1:0]      y
);

	logic [ALU_W-1:0] b_sel;

	always_comb begin
		b_sel = op.inv ? ~b : b;
		y = a + b_sel + {{(ALU_W-1){1'b0}}, op.cin};
	end

endmodule
`default_nettype wire

>>> sv/bend_sensor_to_dac_mapper.sv
// A calibration transfer is absorbed in its accept cycle and gives no result.
// A poll in the deadband or past the limits runs classify, target, difference, negate, a
// 17-step filter multiply, accumulate and code; a mapped poll adds a 16-step divide and
// a 17-step gain multiply, all on the single shared 34-bit adder, so polls never overlap.
// Reset (arst_n low, asynchronous) restores the registers and calibration state.
`default_nettype none
module bend_sensor_to_dac_mapper
	import bsdm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [16:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] bend_sample
	input  wire logic        s_tuser,   // [0] action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [15:0] dac_code, [31:16] active_sample
	output logic [3:0]       m_tuser    // [1:0] bend_state, [2] state_changed, [3] is_active
);

	// configuration
	logic [15:0] zero_q, thr_q, range_q, center_q;
	logic [16:0] alpha_q;

	// persistent state
	logic [15:0] max_q, min_q;
	logic signed [16:0] offset_q;
	logic [31:0] acc_q;
	bend_st_t cur_q, prev_q;

	// working registers
	seq_st_t st_q, st_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0] s_q, dv_q, dsub_q, rem_q, work_q, t_q;
	logic [32:0] hi_q;
	logic [16:0] lo_q;
	logic [31:0] mcand_q, mag_q;
	logic neg_off_q, neg_q, active_q;

	// output register
	logic m_valid_q, chg_q, act_o_q;
	logic [15:0] code_q, samp_o_q;
	bend_st_t bst_o_q;

	// shared unit
	logic [ALU_W-1:0] alu_a, alu_b, alu_y;
	alu_op_t alu_op;

	bsdm_alu u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.op (alu_op),
		.y  (alu_y)
	);

	logic in_acc, out_free, cnt_div_end, cnt_mul_end;
	logic [15:0] s_in;
	logic [16:0] hi_edge, lo_sum, alpha_c, off_mag, mul_lo_nxt;
	logic [32:0] mul_hi_nxt, step_q;
	logic [ALU_W-1:0] mul_sum;
	logic active_c, up_c, dn_c, qbit, rnd;
	logic [16:0] rem_sh;

	assign s_tready = (st_q == SQ_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign cnt_div_end = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign cnt_mul_end = (cnt_q == CNT_W'(MUL_STEPS - 1));

	assign m_tvalid = m_valid_q;
	assign m_tdata = {samp_o_q, code_q};
	assign m_tuser = {act_o_q, chg_q, bst_o_q};

	always_comb begin
		s_in = s_tdata & SAMPLE_MASK;
		hi_edge = {1'b0, zero_q} + {1'b0, thr_q};
		lo_sum = {1'b0, s_q} + {1'b0, thr_q};
		active_c = ({1'b0, s_q} > hi_edge) || (lo_sum < {1'b0, zero_q});
		up_c = (s_q > zero_q) && (s_q < max_q);
		dn_c = (s_q < zero_q) && (s_q > min_q);
		alpha_c = alpha_q[16] ? Q16_ONE : alpha_q;
		off_mag = offset_q[16] ? (~offset_q + 17'd1) : offset_q;
		rem_sh = {rem_q, work_q[15]};
		qbit = !alu_y[ALU_W-1];
		mul_sum = lo_q[0] ? alu_y : {1'b0, hi_q};
		mul_hi_nxt = mul_sum[ALU_W-1:1];
		mul_lo_nxt = {mul_sum[0], lo_q[16:1]};
		step_q = {hi_q[31:0], lo_q[16]};
		rnd = |lo_q[15:0];
	end

	// next state
	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			SQ_IDLE:  if (in_acc && !s_tuser) st_nxt = SQ_CLASS;
			SQ_CLASS: st_nxt = (active_c && (up_c || dn_c)) ? SQ_DIV : SQ_TGT;
			SQ_DIV:   if (cnt_div_end) st_nxt = SQ_MUL1;
			SQ_MUL1:  if (cnt_mul_end) st_nxt = SQ_TGT;
			SQ_TGT:   st_nxt = SQ_DIFF;
			SQ_DIFF:  st_nxt = SQ_NEG;
			SQ_NEG:   st_nxt = SQ_MUL2;
			SQ_MUL2:  if (cnt_mul_end) st_nxt = SQ_ACC;
			SQ_ACC:   st_nxt = SQ_CODE;
			SQ_CODE:  if (out_free) st_nxt = SQ_IDLE;
			default:  st_nxt = SQ_IDLE;
		endcase
	end

	// operand selection for the shared unit
	always_comb begin
		alu_a = '0;
		alu_b = '0;
		alu_op = '{inv: 1'b0, cin: 1'b0};
		unique case (st_q) inside
			SQ_DIV: begin
				alu_a = ALU_W'(rem_sh);
				alu_b = ALU_W'(dv_q);
				alu_op = '{inv: 1'b1, cin: 1'b1};
			end
			SQ_MUL1, SQ_MUL2: begin
				alu_a = ALU_W'(hi_q);
				alu_b = ALU_W'(mcand_q);
			end
			SQ_TGT: begin
				alu_a = ALU_W'(center_q);
				alu_b = ALU_W'(off_mag);
				alu_op = '{inv: offset_q[16], cin: offset_q[16]};
			end
			SQ_DIFF: begin
				alu_a = ALU_W'({t_q, 16'h0000});
				alu_b = ALU_W'(acc_q);
				alu_op = '{inv: 1'b1, cin: 1'b1};
			end
			SQ_NEG: begin
				alu_a = ALU_W'(acc_q);
				alu_b = ALU_W'({t_q, 16'h0000});
				alu_op = '{inv: 1'b1, cin: 1'b1};
			end
			SQ_ACC: begin
				// Negative steps round away from zero, hence the carry only without a fraction.
				alu_a = ALU_W'(acc_q);
				alu_b = ALU_W'(step_q);
				alu_op = '{inv: neg_q, cin: neg_q && !rnd};
			end
			SQ_CODE: begin
				alu_a = ALU_W'(acc_q);
				alu_b = ALU_W'(ROUND_HALF);
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= 16'd32768;
			thr_q <= 16'd512;
			range_q <= 16'd32767;
			center_q <= 16'd32768;
			alpha_q <= 17'd3277;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ZERO_POINT:     zero_q <= cfg_wdata[15:0];
				REG_IDLE_THRESHOLD: thr_q <= cfg_wdata[15:0];
				REG_OUTPUT_RANGE:   range_q <= cfg_wdata[15:0];
				REG_DAC_CENTER:     center_q <= cfg_wdata[15:0];
				REG_FILTER_ALPHA:   alpha_q <= cfg_wdata;
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SQ_IDLE;
			cnt_q <= '0;
			max_q <= 16'd0;
			min_q <= SAMPLE_MASK;
			offset_q <= '0;
			acc_q <= ACC_RESET;
			cur_q <= ST_IDLE;
			prev_q <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (st_q == SQ_CODE && out_free)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			unique case (st_q) inside
				SQ_IDLE: begin
					if (in_acc && s_tuser) begin
						if ({1'b0, s_in} > ({1'b0, zero_q} + CAL_MARGIN)) begin
							if (s_in > max_q)
								max_q <= s_in;
						end else if (({1'b0, s_in} + CAL_MARGIN) < {1'b0, zero_q}) begin
							if (s_in < min_q)
								min_q <= s_in;
						end
					end
				end
				SQ_CLASS: begin
					cnt_q <= '0;
					if (!active_c) begin
						cur_q <= ST_IDLE;
						offset_q <= '0;
					end else if (up_c) begin
						cur_q <= ST_UP;
					end else if (dn_c) begin
						cur_q <= ST_DOWN;
					end
				end
				SQ_DIV: begin
					cnt_q <= cnt_div_end ? '0 : cnt_q + 1'b1;
				end
				SQ_MUL1, SQ_MUL2: begin
					cnt_q <= cnt_mul_end ? '0 : cnt_q + 1'b1;
					if (st_q == SQ_MUL1 && cnt_mul_end)
						offset_q <= neg_off_q ? $signed(~mul_lo_nxt + 17'd1)
							: $signed(mul_lo_nxt);
				end
				SQ_ACC: begin
					acc_q <= alu_y[31:0];
				end
				SQ_CODE: begin
					if (out_free)
						prev_q <= cur_q;
				end
				default: ;
			endcase
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		unique case (st_q) inside
			SQ_IDLE: begin
				s_q <= s_in;
			end
			SQ_CLASS: begin
				active_q <= active_c;
				rem_q <= '0;
				work_q <= range_q;
				hi_q <= '0;
				neg_off_q <= up_c;
				if (up_c) begin
					dv_q <= max_q - zero_q;
					dsub_q <= s_q - zero_q;
				end else begin
					dv_q <= zero_q - min_q;
					dsub_q <= zero_q - s_q;
				end
			end
			SQ_DIV: begin
				rem_q <= qbit ? alu_y[15:0] : rem_sh[15:0];
				work_q <= {work_q[14:0], qbit};
				mcand_q <= {16'h0000, dsub_q};
				if (cnt_div_end)
					lo_q <= {1'b0, work_q[14:0], qbit};
			end
			SQ_MUL1, SQ_MUL2: begin
				hi_q <= mul_hi_nxt;
				lo_q <= mul_lo_nxt;
			end
			SQ_TGT: begin
				if (alu_y[ALU_W-1])
					t_q <= 16'h0000;
				else if (|alu_y[32:16])
					t_q <= 16'hFFFF;
				else
					t_q <= alu_y[15:0];
			end
			SQ_DIFF: begin
				neg_q <= alu_y[ALU_W-1];
				mag_q <= alu_y[31:0];
			end
			SQ_NEG: begin
				hi_q <= '0;
				lo_q <= alpha_c;
				mcand_q <= neg_q ? alu_y[31:0] : mag_q;
			end
			SQ_CODE: begin
				if (out_free) begin
					code_q <= alu_y[32] ? 16'hFFFF : alu_y[31:16];
					bst_o_q <= cur_q;
					chg_q <= (cur_q != prev_q);
					act_o_q <= active_q;
					samp_o_q <= active_q ? s_q : 16'h0000;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> sv/bsdm_monitor.sv
// Port-level checks of the bend sensor mapper, bound to its top level.
`default_nettype none
`include "bend_sensor_to_dac_mapper_defines.svh"
module bsdm_monitor (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [3:0]  m_tuser
);

	// A stalled result must not change under the consumer.
	`BSDM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// Only the three bend states are ever reported.
	`BSDM_ASSERT_NOW(a_state_code, m_tvalid, m_tuser[1:0] != 2'd3)

	// A sample inside the deadband reports idle and echoes nothing.
	`BSDM_ASSERT_NOW(a_idle_result, m_tvalid && !m_tuser[3],
		(m_tdata[31:16] == 16'h0000) && (m_tuser[1:0] == 2'd0))

	// A poll occupies the sequencer, so the input side closes straight after it.
	`BSDM_ASSERT_NEXT(a_poll_busy, s_tvalid && s_tready && !s_tuser, !s_tready)

endmodule

bind bend_sensor_to_dac_mapper bsdm_monitor u_bsdm_monitor (.*);
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the bend sensor to DAC mapper, with its own cycle-free predictor.
module tb;
	import bsdm_pkg::*;

	localparam int SETTLE_CYCLES = 80;
	localparam int PRESSURE_HOLD = 600;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 170;
	localparam int PRESSURE_ITEMS = 24;
	localparam int REPORT_LINES = 40;
	localparam longint Q16 = 65536;
	localparam longint CODE_TOP = 65535;
	localparam longint CAL_GUARD = 1000;
	localparam logic ACT_POLL = 1'b0;
	localparam logic ACT_CAL = 1'b1;

	typedef struct {
		logic [15:0] dac_code;
		bend_st_t    state;
		logic        changed;
		logic        active;
		logic [15:0] echo;
	} poll_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [16:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [15:0] bend_sample
	logic        s_tuser;   // [0] action
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [15:0] dac_code, [31:16] active_sample
	logic [3:0]  m_tuser;   // [1:0] bend_state, [2] state_changed, [3] is_active

	logic hold_start;
	logic no_gaps;
	int   rx_hold;
	int   rx_wait;
	int   quiet_cycles;
	int   mismatches;

	// Shadow of the registers and of the block's calibration and filter state.
	longint   zero_pt, idle_thr, out_range, dac_ctr, alpha_q16;
	longint   max_seen, min_seen, last_ofs, filter_acc;
	bend_st_t cur_st, prev_st;

	poll_result_t dac_results_q[$];

	bend_sensor_to_dac_mapper u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint rnd(input longint lo, input longint hi);
		return lo + longint'($urandom_range(0, int'(hi - lo)));
	endfunction

	function automatic longint clip16(input longint v);
		if (v < 0)
			return 0;
		if (v > CODE_TOP)
			return CODE_TOP;
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic reset_predictor();
		zero_pt = 32768;
		idle_thr = 512;
		out_range = 32767;
		dac_ctr = 32768;
		alpha_q16 = 3277;
		max_seen = 0;
		min_seen = 65535;
		last_ofs = 0;
		filter_acc = 32768 * Q16;
		cur_st = ST_IDLE;
		prev_st = ST_IDLE;
	endtask

	// Calibration only ever widens the limits, and only outside the guard band.
	task automatic absorb_calibration(input logic [15:0] sample);
		longint s;
		s = sample;
		if (s > zero_pt + CAL_GUARD) begin
			if (s > max_seen)
				max_seen = s;
		end else if (s < zero_pt - CAL_GUARD) begin
			if (s < min_seen)
				min_seen = s;
		end
	endtask

	function automatic poll_result_t map_poll(input logic [15:0] sample);
		longint s, ofs, tgt, a, diff, stp, code;
		logic act;
		poll_result_t r;
		s = sample;
		act = (s > zero_pt + idle_thr) || (s < zero_pt - idle_thr);
		if (!act) begin
			ofs = 0;
			cur_st = ST_IDLE;
		end else if (s > zero_pt && s < max_seen) begin
			ofs = -((out_range / (max_seen - zero_pt)) * (s - zero_pt));
			cur_st = ST_UP;
		end else if (s < zero_pt && s > min_seen) begin
			ofs = (out_range / (zero_pt - min_seen)) * (zero_pt - s);
			cur_st = ST_DOWN;
		end else begin
			// Beyond the calibrated limits the previous offset and state stand.
			ofs = last_ofs;
		end
		last_ofs = ofs;
		tgt = clip16(dac_ctr + ofs);
		a = (alpha_q16 > Q16) ? Q16 : alpha_q16;
		diff = tgt * Q16 - filter_acc;
		// Steps towards a lower target round away from zero.
		if (diff >= 0)
			stp = (a * diff) / Q16;
		else
			stp = -((a * (-diff) + Q16 - 1) / Q16);
		filter_acc = (filter_acc + stp) & 64'hFFFF_FFFF;
		code = (filter_acc + 32768) >> 16;
		if (code > CODE_TOP)
			code = CODE_TOP;
		r.dac_code = code[15:0];
		r.state = cur_st;
		r.changed = (cur_st != prev_st);
		prev_st = cur_st;
		r.active = act;
		r.echo = act ? sample : 16'd0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= REPORT_LINES)
			$display("%0t: %s mismatch, got %0d, wanted %0d", $time, what, got, want);
	endtask

	task automatic send_item(input logic act, input logic [15:0] sample);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= sample;
		do @(posedge clk); while (!s_tready);
		if (act == ACT_CAL)
			absorb_calibration(sample);
		else
			dac_results_q.push_back(map_poll(sample));
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [2:0] addr, input longint value);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= 17'(value);
		@(posedge clk);
		case (addr)
			REG_ZERO_POINT: zero_pt = value & 16'hFFFF;
			REG_IDLE_THRESHOLD: idle_thr = value & 16'hFFFF;
			REG_OUTPUT_RANGE: out_range = value & 16'hFFFF;
			REG_DAC_CENTER: dac_ctr = value & 16'hFFFF;
			REG_FILTER_ALPHA: alpha_q16 = value & 17'h1FFFF;
			default: ;
		endcase
	endtask

	task automatic set_registers(input longint zero, input longint thr, input longint range,
			input longint centre, input longint alpha);
		write_reg(REG_ZERO_POINT, zero);
		write_reg(REG_IDLE_THRESHOLD, thr);
		write_reg(REG_OUTPUT_RANGE, range);
		write_reg(REG_DAC_CENTER, centre);
		write_reg(REG_FILTER_ALPHA, alpha);
		cfg_we <= 1'b0;
	endtask

	// Registers change only once every poll has produced its result.
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (dac_results_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_poll_sample();
		longint v;
		case ($urandom_range(0, 9))
			0: v = zero_pt + ($urandom_range(0, 1) ? 1 : -1) * (idle_thr + rnd(0, 1));
			1: v = rnd(0, 65535);
			2: v = ($urandom_range(0, 1) ? max_seen : min_seen) + rnd(-1, 1);
			3, 4, 5: v = (max_seen > zero_pt) ? rnd(zero_pt, max_seen) : rnd(0, 65535);
			6, 7, 8: v = (min_seen < zero_pt) ? rnd(min_seen, zero_pt) : rnd(0, 65535);
			default: v = zero_pt + rnd(-idle_thr, idle_thr);
		endcase
		return 16'(clip16(v));
	endfunction

	function automatic logic [15:0] pick_cal_sample(input longint span);
		longint v;
		if ($urandom_range(0, 9) == 0)
			v = rnd(0, 65535);
		else
			v = zero_pt + ($urandom_range(0, 1) ? 1 : -1) * rnd(CAL_GUARD + 1, CAL_GUARD + span);
		return 16'(clip16(v));
	endfunction

	task automatic test_reset_values();
		send_item(ACT_POLL, 16'd32768);
		send_item(ACT_POLL, 16'd33280);
		// Active but nothing calibrated yet: offset and state are held.
		send_item(ACT_POLL, 16'd33281);
		send_item(ACT_POLL, 16'd32255);
		drain_block();
	endtask

	task automatic test_calibration();
		send_item(ACT_CAL, 16'd33768);
		send_item(ACT_CAL, 16'd33769);
		send_item(ACT_CAL, 16'd40000);
		send_item(ACT_CAL, 16'd35000);
		send_item(ACT_CAL, 16'd31768);
		send_item(ACT_CAL, 16'd30000);
		send_item(ACT_CAL, 16'd31000);
		send_item(ACT_POLL, 16'd36000);
		send_item(ACT_POLL, 16'd39999);
		send_item(ACT_POLL, 16'd40000);
		send_item(ACT_POLL, 16'd65535);
		send_item(ACT_POLL, 16'd20000);
		send_item(ACT_POLL, 16'd30001);
		send_item(ACT_POLL, 16'd32000);
		send_item(ACT_POLL, 16'd0);
		drain_block();
	endtask

	task automatic test_register_extremes();
		// Zero point at the bottom, no deadband, target driven below zero.
		set_registers(0, 0, 65535, 0, Q16);
		send_item(ACT_POLL, 16'd0);
		send_item(ACT_POLL, 16'd65535);
		send_item(ACT_POLL, 16'd20000);
		drain_block();
		// Writes to indexes past the last register must leave everything alone.
		for (int a = int'(REG_FILTER_ALPHA) + 1; a < 8; a++)
			write_reg(3'(a), longint'($urandom_range(0, 131071)));
		// The deadband is not clipped at either end of the sample range.
		set_registers(65535, 65535, 0, 65535, 131071);
		send_item(ACT_POLL, 16'd0);
		send_item(ACT_POLL, 16'd65535);
		drain_block();
		set_registers(32768, 0, 65535, 65535, Q16);
		send_item(ACT_POLL, 16'd30001);
		send_item(ACT_POLL, 16'd32768);
		drain_block();
		set_registers(32768, 0, 0, 32768, 0);
		send_item(ACT_POLL, 16'd36000);
		drain_block();
	endtask

	task automatic test_backpressure();
		set_registers(32768, 256, 32767, 32768, 20000);
		no_gaps = 1'b1;
		hold_start <= 1'b1;
		@(posedge clk);
		hold_start <= 1'b0;
		for (int i = 0; i < PRESSURE_ITEMS; i++)
			send_item(ACT_POLL, pick_poll_sample());
		drain_block();
		no_gaps = 1'b0;
	endtask

	task automatic test_random_phases();
		longint span, zero, thr, range, centre, alpha;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 9))
				0: zero = 0;
				1: zero = 65535;
				2, 3: zero = rnd(0, 65535);
				default: zero = rnd(24768, 40768);
			endcase
			case ($urandom_range(0, 9))
				0: thr = 0;
				1: thr = 65535;
				2: thr = rnd(0, 65535);
				default: thr = rnd(0, 2000);
			endcase
			case ($urandom_range(0, 5))
				0: range = 0;
				1: range = 65535;
				default: range = rnd(0, 65535);
			endcase
			case ($urandom_range(0, 5))
				0: centre = 0;
				1: centre = 65535;
				default: centre = rnd(0, 65535);
			endcase
			case ($urandom_range(0, 5))
				0: alpha = 0;
				1: alpha = Q16;
				2: alpha = rnd(Q16 + 1, 131071);
				default: alpha = rnd(1, Q16);
			endcase
			set_registers(zero, thr, range, centre, alpha);
			// The calibrated span grows from phase to phase so that gains vary.
			span = (p == RANDOM_PHASES - 1) ? 65535 : 1500 * (1 << p);
			no_gaps = (p == 2);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 4) == 0)
					send_item(ACT_CAL, pick_cal_sample(span));
				else
					send_item(ACT_POLL, pick_poll_sample());
			end
			drain_block();
		end
		no_gaps = 1'b0;
	endtask

	always @(posedge clk) begin
		if (hold_start)
			rx_hold = PRESSURE_HOLD;
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			rx_wait = no_gaps ? 0 : pick_gap();
		end
	end

	always @(posedge clk) begin
		poll_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (dac_results_q.size() == 0) begin
				report_mismatch("unpredicted result, dac_code", m_tdata[15:0], 0);
			end else begin
				want = dac_results_q.pop_front();
				if (m_tdata[15:0] !== want.dac_code)
					report_mismatch("dac_code", m_tdata[15:0], want.dac_code);
				if (m_tuser[1:0] !== want.state)
					report_mismatch("bend_state", m_tuser[1:0], want.state);
				if (m_tuser[2] !== want.changed)
					report_mismatch("state_changed", m_tuser[2], want.changed);
				if (m_tuser[3] !== want.active)
					report_mismatch("is_active", m_tuser[3], want.active);
				if (m_tdata[31:16] !== want.echo)
					report_mismatch("active_sample", m_tdata[31:16], want.echo);
			end
		end
	end

	// Ends a hung run: counts cycles in which neither side completes a transfer.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		hold_start = 1'b0;
		no_gaps = 1'b0;
		rx_hold = 0;
		rx_wait = 0;
		quiet_cycles = 0;
		mismatches = 0;
		reset_predictor();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_calibration();
		test_register_extremes();
		test_backpressure();
		test_random_phases();
		drain_block();
		if (mismatches == 0 && dac_results_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
